// ----- rtl/core/mqpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT packet field parser package
// Shared types, codes and constants for the parser core, the output buffer
// and the top level.
// ----------------------------------------------------------------------------
package mqpp_pkg;

    // Packet types carried in the upper nibble of the fixed header
    localparam logic [3:0]  TYPE_CONNECT  = 4'd1;
    localparam logic [3:0]  TYPE_PUBLISH  = 4'd3;

    // CONNECT protocol name and level bytes that are skipped
    localparam logic [15:0] PROTO_SKIP    = 16'd7;

    // Remaining length takes at most four encoded bytes
    localparam logic [2:0]  LEN_BYTES_MAX = 3'd4;

    // Last CONNECT string slot (client id, will topic, will msg, user, pass)
    localparam logic [2:0]  STR_LAST      = 3'd4;

    // Parser phase
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEN,
        PH_PROTO,
        PH_FLAGS,
        PH_KA_HI,
        PH_KA_LO,
        PH_SLEN_HI,
        PH_SLEN_LO,
        PH_SBODY,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_PID_HI,
        PH_PID_LO,
        PH_PAYLOAD
    } phase_t;

    // Field role tag attached to each byte
    typedef enum logic [3:0] {
        ROLE_HEADER,
        ROLE_LENGTH,
        ROLE_PROTO,
        ROLE_FLAGS,
        ROLE_KEEPALIVE,
        ROLE_STRLEN,
        ROLE_CLIENTID,
        ROLE_WILLTOPIC,
        ROLE_WILLMSG,
        ROLE_USER,
        ROLE_PASS,
        ROLE_TOPIC,
        ROLE_PKTID,
        ROLE_PAYLOAD,
        ROLE_OTHER
    } role_t;

    // Packet status reported with last_of_packet
    typedef enum logic [1:0] {
        ST_OK,
        ST_LEN_TOO_LONG,
        ST_MISMATCH,
        ST_UNSUPPORTED
    } status_t;

    // Input transfer
    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_packet;
    } in_item_t;

    // Output transfer
    typedef struct packed {
        logic [7:0]  data_byte;
        role_t       role;
        logic        last_of_packet;
        status_t     status;
        logic [27:0] decoded_length;
        logic [7:0]  connect_flags;
        logic [15:0] keepalive;
        logic [15:0] packet_id;
        logic [27:0] payload_length;
    } out_item_t;

endpackage

// ----- rtl/core/mqpp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT packet field parser core
// Per-byte decode of the packet structure. Parser state advances on each
// accepted byte; the tagged result is produced combinationally.
// ----------------------------------------------------------------------------
module mqpp_core
    import mqpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    output out_item_t result
);

    // State registers
    phase_t      phase_reg,       phase_next;
    logic [7:0]  header_reg,      header_next;
    logic [27:0] length_accum_reg, length_accum_next;
    logic [2:0]  len_count_reg,   len_count_next;
    logic [27:0] bytes_left_reg,  bytes_left_next;
    logic [15:0] field_count_reg, field_count_next;
    logic [2:0]  str_index_reg,   str_index_next;
    logic [7:0]  flags_reg,       flags_next;
    logic [15:0] keepalive_reg,   keepalive_next;
    logic [15:0] packet_id_reg,   packet_id_next;
    logic [15:0] topic_len_reg,   topic_len_next;
    logic [27:0] payload_len_reg, payload_len_next;

    // Decode signals
    logic [27:0] len_group;
    logic [27:0] accum_sum;
    logic        len_final;
    logic        len_overflow;
    logic        hdr_supported;
    logic        qos_nonzero;
    logic [15:0] fc_dec;
    logic [15:0] slen_full;
    logic [15:0] topic_full;
    logic [17:0] pub_need;
    logic [27:0] pub_payload;
    logic        str_found;
    logic [2:0]  str_next;
    logic        body_active;
    logic        is_pub;
    logic        done;
    logic        len_end;
    logic        payload_reached;

    function automatic logic str_present(input logic [2:0] idx, input logic [7:0] flags);
        logic present;
        present = 1'b0;
        case (idx)
            3'd0:      present = 1'b1;
            3'd1:      present = flags[2];
            3'd2:      present = flags[2];
            3'd3:      present = flags[7];
            3'd4:      present = flags[6];
            default:   present = 1'b0;
        endcase
        return present;
    endfunction

    // Remaining length group placed at its 7-bit position
    always_comb
    begin
        case (len_count_reg[1:0])
            2'd0:    len_group = {21'd0, item.in_byte[6:0]};
            2'd1:    len_group = {14'd0, item.in_byte[6:0], 7'd0};
            2'd2:    len_group = {7'd0, item.in_byte[6:0], 14'd0};
            default: len_group = {item.in_byte[6:0], 21'd0};
        endcase
    end

    assign accum_sum     = length_accum_reg + len_group;
    assign len_final     = !item.in_byte[7];
    assign len_overflow  = (len_count_reg >= LEN_BYTES_MAX);
    assign hdr_supported = (item.in_byte[7:4] == TYPE_CONNECT) ||
                           (item.in_byte[7:4] == TYPE_PUBLISH);
    assign qos_nonzero   = (header_reg[2:1] != 2'd0);
    assign fc_dec        = field_count_reg - 16'd1;
    assign slen_full     = {field_count_reg[15:8], item.in_byte};
    assign topic_full    = {topic_len_reg[15:8], item.in_byte};

    // PUBLISH payload length, clamped at zero on underflow
    assign pub_need    = 18'(topic_full) + (qos_nonzero ? 18'd4 : 18'd2);
    assign pub_payload = (length_accum_reg >= 28'(pub_need)) ?
                         (length_accum_reg - 28'(pub_need)) : 28'd0;

    // Next present CONNECT string after the current one
    always_comb
    begin
        str_found = 1'b0;
        str_next  = str_index_reg;
        for (int i = 4; i >= 1; i--)
        begin
            if ((3'(i) > str_index_reg) && str_present(3'(i), flags_reg))
            begin
                str_found = 1'b1;
                str_next  = 3'(i);
            end
        end
    end

    // Structure-complete decode for the variable header walk
    assign body_active = !item.start_of_packet && (phase_reg != PH_IDLE) &&
                         (phase_reg != PH_LEN);
    assign is_pub      = (phase_reg >= PH_TLEN_HI);
    assign len_end     = ((bytes_left_reg - 28'd1) == 28'd0);

    always_comb
    begin
        case (phase_reg)
            PH_SLEN_LO: done = (slen_full == 16'd0) && !str_found;
            PH_SBODY:   done = (fc_dec == 16'd0) && !str_found;
            PH_TLEN_LO: done = (topic_full == 16'd0) && !qos_nonzero;
            PH_TOPIC:   done = (fc_dec == 16'd0) && !qos_nonzero;
            PH_PID_LO:  done = 1'b1;
            default:    done = 1'b0;
        endcase
    end

    assign payload_reached = done || (phase_reg == PH_PAYLOAD);

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        header_next       = header_reg;
        length_accum_next = length_accum_reg;
        len_count_next    = len_count_reg;
        bytes_left_next   = bytes_left_reg;
        field_count_next  = field_count_reg;
        str_index_next    = str_index_reg;
        flags_next        = flags_reg;
        keepalive_next    = keepalive_reg;
        packet_id_next    = packet_id_reg;
        topic_len_next    = topic_len_reg;
        payload_len_next  = payload_len_reg;

        if (item.start_of_packet)
        begin
            header_next       = item.in_byte;
            length_accum_next = 28'd0;
            len_count_next    = 3'd0;
            bytes_left_next   = 28'd0;
            field_count_next  = 16'd0;
            str_index_next    = 3'd0;
            flags_next        = 8'd0;
            keepalive_next    = 16'd0;
            packet_id_next    = 16'd0;
            topic_len_next    = 16'd0;
            payload_len_next  = 28'd0;
            phase_next        = hdr_supported ? PH_LEN : PH_IDLE;
        end
        else if (phase_reg == PH_LEN)
        begin
            if (len_overflow)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                length_accum_next = accum_sum;
                len_count_next    = len_count_reg + 3'd1;
                if (len_final)
                begin
                    bytes_left_next = accum_sum;
                    if (accum_sum == 28'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (header_reg[7:4] == TYPE_CONNECT)
                    begin
                        field_count_next = PROTO_SKIP;
                        phase_next       = PH_PROTO;
                    end
                    else
                    begin
                        phase_next = PH_TLEN_HI;
                    end
                end
            end
        end
        else if (body_active)
        begin
            bytes_left_next = bytes_left_reg - 28'd1;
            case (phase_reg)
                PH_PROTO:
                begin
                    field_count_next = fc_dec;
                    if (fc_dec == 16'd0)
                        phase_next = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    flags_next = item.in_byte;
                    phase_next = PH_KA_HI;
                end
                PH_KA_HI:
                begin
                    keepalive_next = {item.in_byte, 8'd0};
                    phase_next     = PH_KA_LO;
                end
                PH_KA_LO:
                begin
                    keepalive_next = {keepalive_reg[15:8], item.in_byte};
                    str_index_next = 3'd0;
                    phase_next     = PH_SLEN_HI;
                end
                PH_SLEN_HI:
                begin
                    field_count_next = {item.in_byte, 8'd0};
                    phase_next       = PH_SLEN_LO;
                end
                PH_SLEN_LO:
                begin
                    field_count_next = slen_full;
                    if (slen_full != 16'd0)
                    begin
                        phase_next = PH_SBODY;
                    end
                    else if (str_found)
                    begin
                        str_index_next = str_next;
                        phase_next     = PH_SLEN_HI;
                    end
                end
                PH_SBODY:
                begin
                    field_count_next = fc_dec;
                    if ((fc_dec == 16'd0) && str_found)
                    begin
                        str_index_next = str_next;
                        phase_next     = PH_SLEN_HI;
                    end
                end
                PH_TLEN_HI:
                begin
                    topic_len_next = {item.in_byte, 8'd0};
                    phase_next     = PH_TLEN_LO;
                end
                PH_TLEN_LO:
                begin
                    topic_len_next   = topic_full;
                    payload_len_next = pub_payload;
                    if (topic_full != 16'd0)
                    begin
                        field_count_next = topic_full;
                        phase_next       = PH_TOPIC;
                    end
                    else if (qos_nonzero)
                    begin
                        phase_next = PH_PID_HI;
                    end
                end
                PH_TOPIC:
                begin
                    field_count_next = fc_dec;
                    if ((fc_dec == 16'd0) && qos_nonzero)
                        phase_next = PH_PID_HI;
                end
                PH_PID_HI:
                begin
                    packet_id_next = {item.in_byte, 8'd0};
                    phase_next     = PH_PID_LO;
                end
                PH_PID_LO:
                begin
                    packet_id_next = {packet_id_reg[15:8], item.in_byte};
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // End of packet: structure complete or length used up
            if (!is_pub)
            begin
                if (done || len_end)
                    phase_next = PH_IDLE;
            end
            else
            begin
                if (done)
                    phase_next = PH_PAYLOAD;
                if (len_end)
                    phase_next = PH_IDLE;
            end
        end
    end

    // Result fields
    always_comb
    begin
        result.data_byte        = item.in_byte;
        result.role             = ROLE_OTHER;
        result.last_of_packet   = 1'b0;
        result.status           = ST_OK;
        result.decoded_length   = length_accum_next;
        result.connect_flags    = flags_next;
        result.keepalive        = keepalive_next;
        result.packet_id        = packet_id_next;
        result.payload_length   = payload_len_next;

        if (item.start_of_packet)
        begin
            result.role = ROLE_HEADER;
            if (!hdr_supported)
            begin
                result.last_of_packet = 1'b1;
                result.status         = ST_UNSUPPORTED;
            end
        end
        else if (phase_reg == PH_LEN)
        begin
            result.role = ROLE_LENGTH;
            if (len_overflow)
            begin
                result.last_of_packet = 1'b1;
                result.status         = ST_LEN_TOO_LONG;
            end
            else if (len_final && (accum_sum == 28'd0))
            begin
                result.last_of_packet = 1'b1;
                result.status         = ST_MISMATCH;
            end
        end
        else if (body_active)
        begin
            case (phase_reg)
                PH_PROTO:   result.role = ROLE_PROTO;
                PH_FLAGS:   result.role = ROLE_FLAGS;
                PH_KA_HI:   result.role = ROLE_KEEPALIVE;
                PH_KA_LO:   result.role = ROLE_KEEPALIVE;
                PH_SLEN_HI: result.role = ROLE_STRLEN;
                PH_SLEN_LO: result.role = ROLE_STRLEN;
                PH_SBODY:   result.role = role_t'(4'(ROLE_CLIENTID) +
                                ((str_index_reg <= STR_LAST) ? {1'b0, str_index_reg}
                                                             : {1'b0, STR_LAST}));
                PH_TLEN_HI: result.role = ROLE_STRLEN;
                PH_TLEN_LO: result.role = ROLE_STRLEN;
                PH_TOPIC:   result.role = ROLE_TOPIC;
                PH_PID_HI:  result.role = ROLE_PKTID;
                PH_PID_LO:  result.role = ROLE_PKTID;
                default:    result.role = ROLE_PAYLOAD;
            endcase

            if (!is_pub)
            begin
                if (done || len_end)
                begin
                    result.last_of_packet = 1'b1;
                    if (!(done && len_end))
                        result.status = ST_MISMATCH;
                end
            end
            else if (len_end)
            begin
                result.last_of_packet = 1'b1;
                if (!payload_reached)
                    result.status = ST_MISMATCH;
            end
        end
    end

    // State update on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            header_reg       <= 8'd0;
            length_accum_reg <= 28'd0;
            len_count_reg    <= 3'd0;
            bytes_left_reg   <= 28'd0;
            field_count_reg  <= 16'd0;
            str_index_reg    <= 3'd0;
            flags_reg        <= 8'd0;
            keepalive_reg    <= 16'd0;
            packet_id_reg    <= 16'd0;
            topic_len_reg    <= 16'd0;
            payload_len_reg  <= 28'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            header_reg       <= header_next;
            length_accum_reg <= length_accum_next;
            len_count_reg    <= len_count_next;
            bytes_left_reg   <= bytes_left_next;
            field_count_reg  <= field_count_next;
            str_index_reg    <= str_index_next;
            flags_reg        <= flags_next;
            keepalive_reg    <= keepalive_next;
            packet_id_reg    <= packet_id_next;
            topic_len_reg    <= topic_len_next;
            payload_len_reg  <= payload_len_next;
        end
    end

    // A packet end always leaves the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.last_of_packet |=> phase_reg == PH_IDLE)
        else $error("parser not idle after last byte of packet");

    // Length byte counter never passes the encoding limit
    assert property (@(posedge clk) disable iff (!rst_n)
        len_count_reg <= LEN_BYTES_MAX)
        else $error("length byte count beyond limit");

    // An error status only ever closes a packet
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (result.status != ST_OK) |-> result.last_of_packet)
        else $error("error status without last_of_packet");

endmodule

// ----- rtl/core/mqpp_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT packet field parser output buffer
// Output register with a skid entry, so the input side is stalled by a
// register only and a new byte can be taken while a result waits.
// ----------------------------------------------------------------------------
module mqpp_out_buf
    import mqpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      full,
    output logic      valid,
    input  logic      stall,
    output out_item_t data
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;

    // Buffer control
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign data  = out_data_reg;

    // Skid entry only holds data behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // Skid entry fills only while the output was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && stall))
        else $error("skid entry filled without a stalled output");

    // Skid entry drains as soon as the output moves
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !stall |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not drained after transfer");

endmodule

// ----- rtl/core/mqtt_packet_field_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT packet field parser
// Tags each byte of an MQTT 3.1.1 CONNECT or PUBLISH stream with its field
// role and reports the decoded header values.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the input is not stalled, with one
// result per byte. Each result is registered in the output buffer as its byte
// is transferred in, and the parser state is updated in that same cycle, so
// back-to-back bytes need no gaps. The output side has a two-entry buffer
// (output register plus skid entry): the input is stalled only once both
// entries hold results, and the input stall comes straight from a register.
// ----------------------------------------------------------------------------
module mqtt_packet_field_parser
    import mqpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic      accept;
    logic      buf_full;
    out_item_t core_result;

    // Input transfer
    assign item_stall = buf_full;
    assign accept     = item_valid && !buf_full;

    mqpp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .result (core_result)
    );

    mqpp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (buf_full),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (result)
    );

endmodule

// ----- sim/mqtt_packet_field_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT packet field parser testbench
// Streams CONNECT, PUBLISH and malformed packets into the parser through the
// valid/stall input channel. Each transferred byte runs through a local model
// of the field tagger, and every output transfer is compared field by field
// against the oldest predicted tag. The stream starts with a short directed
// part and then runs random packets under four flow-control mixes.
// ----------------------------------------------------------------------------
module mqtt_packet_field_parser_test;
    import mqpp_pkg::*;

    typedef logic [7:0] byte_list_t[$];

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1025;
    localparam int PRINT_LIMIT  = 40;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // Byte stream waiting to be driven, and predicted tags awaiting results
    in_item_t  pending_bytes[$];
    out_item_t expected_tags[$];

    // Flow-control mix for the current phase (percent)
    int phase_idle_pct[4]  = '{0, 77, 0, 22};
    int phase_stall_pct[4] = '{0, 0, 77, 22};
    int send_idle_pct      = 0;
    int recv_stall_pct     = 0;

    logic item_fire   = 1'b0;
    int   cycle_count = 0;
    int   error_count = 0;
    int   bytes_checked = 0;
    int   connect_pkts = 0;
    int   publish_pkts = 0;
    int   malformed_pkts = 0;
    int   status_tally[4] = '{0, 0, 0, 0};

    // Parser state mirror
    phase_t      parse_phase   = PH_IDLE;
    logic [7:0]  hdr_byte      = '0;
    logic [27:0] len_acc       = '0;
    logic [2:0]  len_groups    = '0;
    logic [27:0] bytes_left    = '0;
    logic [15:0] field_cnt     = '0;
    logic [2:0]  str_idx       = '0;
    logic [7:0]  conn_flags    = '0;
    logic [15:0] keepalive_val = '0;
    logic [15:0] pkt_id        = '0;
    logic [15:0] topic_len     = '0;
    logic [27:0] payload_len   = '0;

    mqtt_packet_field_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Field tag prediction
    // ------------------------------------------------------------------------

    // Step to the next CONNECT string that the flags call for; 1 when none left
    function automatic bit advance_string();
        bit present;
        for (int i = str_idx + 1; i <= STR_LAST; i++) begin
            case (i)
                1, 2:    present = conn_flags[2];
                3:       present = conn_flags[7];
                default: present = conn_flags[6];
            endcase
            if (present) begin
                str_idx     = 3'(i);
                parse_phase = PH_SLEN_HI;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic out_item_t predict_field_tag(in_item_t it);
        out_item_t  res;
        logic [7:0] b;
        bit         done;
        bit         is_pub;
        bit         qos_on;
        int         need;
        b                  = it.in_byte;
        res.role           = ROLE_OTHER;
        res.last_of_packet = 1'b0;
        res.status         = ST_OK;
        done               = 1'b0;
        qos_on             = hdr_byte[2:1] != 2'd0;

        if (it.start_of_packet) begin
            // Header always restarts, dropping any unfinished packet
            hdr_byte      = b;
            len_acc       = '0;
            len_groups    = '0;
            bytes_left    = '0;
            field_cnt     = '0;
            str_idx       = '0;
            conn_flags    = '0;
            keepalive_val = '0;
            pkt_id        = '0;
            topic_len     = '0;
            payload_len   = '0;
            res.role      = ROLE_HEADER;
            if (b[7:4] == TYPE_CONNECT || b[7:4] == TYPE_PUBLISH) begin
                parse_phase = PH_LEN;
            end else begin
                parse_phase        = PH_IDLE;
                res.status         = ST_UNSUPPORTED;
                res.last_of_packet = 1'b1;
            end
        end else if (parse_phase == PH_IDLE) begin
            // stray byte: tagged as other, state untouched
        end else if (parse_phase == PH_LEN) begin
            res.role = ROLE_LENGTH;
            if (len_groups >= LEN_BYTES_MAX) begin
                res.status         = ST_LEN_TOO_LONG;
                res.last_of_packet = 1'b1;
                parse_phase        = PH_IDLE;
            end else begin
                len_acc    = len_acc + (28'(b[6:0]) << (7 * len_groups));
                len_groups = len_groups + 3'd1;
                if (!b[7]) begin
                    bytes_left = len_acc;
                    if (len_acc == '0) begin
                        res.status         = ST_MISMATCH;
                        res.last_of_packet = 1'b1;
                        parse_phase        = PH_IDLE;
                    end else if (hdr_byte[7:4] == TYPE_CONNECT) begin
                        field_cnt   = PROTO_SKIP;
                        parse_phase = PH_PROTO;
                    end else begin
                        parse_phase = PH_TLEN_HI;
                    end
                end
            end
        end else begin
            is_pub     = parse_phase >= PH_TLEN_HI;
            bytes_left = bytes_left - 28'd1;
            case (parse_phase)
                PH_PROTO: begin
                    res.role  = ROLE_PROTO;
                    field_cnt = field_cnt - 16'd1;
                    if (field_cnt == '0) parse_phase = PH_FLAGS;
                end
                PH_FLAGS: begin
                    res.role    = ROLE_FLAGS;
                    conn_flags  = b;
                    parse_phase = PH_KA_HI;
                end
                PH_KA_HI: begin
                    res.role      = ROLE_KEEPALIVE;
                    keepalive_val = {b, 8'h00};
                    parse_phase   = PH_KA_LO;
                end
                PH_KA_LO: begin
                    res.role           = ROLE_KEEPALIVE;
                    keepalive_val[7:0] = b;
                    str_idx            = '0;
                    parse_phase        = PH_SLEN_HI;
                end
                PH_SLEN_HI: begin
                    res.role    = ROLE_STRLEN;
                    field_cnt   = {b, 8'h00};
                    parse_phase = PH_SLEN_LO;
                end
                PH_SLEN_LO: begin
                    res.role       = ROLE_STRLEN;
                    field_cnt[7:0] = b;
                    if (field_cnt != '0) parse_phase = PH_SBODY;
                    else done = advance_string();
                end
                PH_SBODY: begin
                    res.role  = role_t'(int'(ROLE_CLIENTID) + int'(str_idx));
                    field_cnt = field_cnt - 16'd1;
                    if (field_cnt == '0) done = advance_string();
                end
                PH_TLEN_HI: begin
                    res.role    = ROLE_STRLEN;
                    topic_len   = {b, 8'h00};
                    parse_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    res.role       = ROLE_STRLEN;
                    topic_len[7:0] = b;
                    need           = 2 + topic_len + (qos_on ? 2 : 0);
                    // underflow reads as zero rather than wrapping
                    payload_len    = (len_acc >= need) ? 28'(len_acc - need) : '0;
                    if (topic_len != '0) begin
                        field_cnt   = topic_len;
                        parse_phase = PH_TOPIC;
                    end else if (qos_on) begin
                        parse_phase = PH_PID_HI;
                    end else begin
                        done = 1'b1;
                    end
                end
                PH_TOPIC: begin
                    res.role  = ROLE_TOPIC;
                    field_cnt = field_cnt - 16'd1;
                    if (field_cnt == '0) begin
                        if (qos_on) parse_phase = PH_PID_HI;
                        else done = 1'b1;
                    end
                end
                PH_PID_HI: begin
                    res.role    = ROLE_PKTID;
                    pkt_id      = {b, 8'h00};
                    parse_phase = PH_PID_LO;
                end
                PH_PID_LO: begin
                    res.role    = ROLE_PKTID;
                    pkt_id[7:0] = b;
                    done        = 1'b1;
                end
                default: res.role = ROLE_PAYLOAD;
            endcase

            // End of packet: structure and remaining length must run out together
            if (!is_pub) begin
                if (done || bytes_left == '0) begin
                    res.last_of_packet = 1'b1;
                    if (!(done && bytes_left == '0)) res.status = ST_MISMATCH;
                    parse_phase = PH_IDLE;
                end
            end else begin
                if (done) parse_phase = PH_PAYLOAD;
                if (bytes_left == '0) begin
                    res.last_of_packet = 1'b1;
                    if (parse_phase != PH_PAYLOAD) res.status = ST_MISMATCH;
                    parse_phase = PH_IDLE;
                end
            end
        end

        res.data_byte        = b;
        res.decoded_length   = len_acc;
        res.connect_flags    = conn_flags;
        res.keepalive        = keepalive_val;
        res.packet_id        = pkt_id;
        res.payload_length   = payload_len;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------------
    task automatic report_error(input string what);
        // only the first few are printed, all are counted
        if (error_count < PRINT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [27:0] got,
                               input logic [27:0] want);
        if (got !== want)
            report_error($sformatf("byte %0d field %s: got 0x%0h, expected 0x%0h",
                                   bytes_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Input driver: presents queued bytes at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (!item_valid || item_fire) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item       <= pending_bytes.pop_front();
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on input transfers, checks output transfers
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        out_item_t want;
        out_item_t tag;
        if (rst_n) begin
            item_fire <= item_valid && !item_stall;
            if (item_valid && !item_stall) begin
                tag = predict_field_tag(item);
                if (tag.last_of_packet) status_tally[int'(tag.status)]++;
                expected_tags.push_back(tag);
            end
            if (result_valid && !result_stall) begin
                if (expected_tags.size() == 0) begin
                    report_error($sformatf("result transfer with nothing expected, byte 0x%0h",
                                           result.data_byte));
                end else begin
                    want = expected_tags.pop_front();
                    check_field("data_byte", result.data_byte, want.data_byte);
                    check_field("role", result.role, want.role);
                    check_field("last_of_packet", result.last_of_packet, want.last_of_packet);
                    check_field("status", result.status, want.status);
                    check_field("decoded_length", result.decoded_length,
                                want.decoded_length);
                    check_field("connect_flags", result.connect_flags, want.connect_flags);
                    check_field("keepalive", result.keepalive, want.keepalive);
                    check_field("packet_id", result.packet_id, want.packet_id);
                    check_field("payload_length", result.payload_length, want.payload_length);
                end
                bytes_checked++;
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic sop);
        in_item_t t;
        t.in_byte         = b;
        t.start_of_packet = sop;
        pending_bytes.push_back(t);
    endtask

    // Remaining length, low group first; pad adds redundant zero groups
    task automatic push_length(input int unsigned len, input bit pad);
        byte_list_t  grp;
        int unsigned v;
        v = len;
        do begin
            grp.push_back({1'b0, v[6:0]});
            v = v >> 7;
        end while (v != 0);
        if (pad && grp.size() < 4) repeat ($urandom_range(1, 4 - grp.size())) grp.push_back(8'h00);
        for (int i = 0; i < grp.size() - 1; i++) grp[i][7] = 1'b1;
        foreach (grp[i]) push_byte(grp[i], 1'b0);
    endtask

    // Mostly short fields, now and then a long one of 128 to 300 bytes, at times needing a high byte
    function automatic int pick_len(input int short_max);
        if ($urandom_range(99) < 4) return $urandom_range(128, 300);
        return $urandom_range(0, short_max);
    endfunction

    task automatic add_string(ref byte_list_t body, input int n);
        body.push_back(8'(n >> 8));
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom));
    endtask

    // Header, length (declared = body size + delta), body, then any excess bytes
    task automatic send_packet(input logic [7:0] hdr, input byte_list_t body,
                               input int delta, input bit pad);
        push_byte(hdr, 1'b1);
        push_length(body.size() + delta, pad);
        foreach (body[i]) push_byte(body[i], 1'b0);
        if (delta > 0) repeat (delta) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic gen_connect(input bit broken);
        byte_list_t body;
        logic [7:0] flags;
        int         delta;
        delta = 0;
        if ($urandom_range(3) != 0)
            body = '{8'h00, 8'h04, 8'h4D, 8'h51, 8'h54, 8'h54, 8'h04};
        else
            repeat (7) body.push_back(8'($urandom));
        flags = 8'($urandom);
        body.push_back(flags);
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        for (int s = 0; s <= 4; s++) begin
            if (s == 0 || (s < 3 && flags[2]) || (s == 3 && flags[7]) || (s == 4 && flags[6]))
                add_string(body, pick_len(6));
        end
        if (broken) begin
            if ($urandom_range(1)) begin
                // garbage client id length: runs out of bytes inside the string
                body[10] = 8'($urandom);
                body[11] = 8'($urandom);
            end else begin
                delta = $urandom_range(1, 4);
                if ($urandom_range(1)) delta = -delta;
            end
        end
        send_packet({TYPE_CONNECT, 4'($urandom)}, body, delta, $urandom_range(7) == 0);
    endtask

    task automatic gen_publish(input bit broken);
        byte_list_t body;
        logic [7:0] hdr;
        int         delta;
        delta = 0;
        hdr   = {TYPE_PUBLISH, 4'($urandom)};
        add_string(body, pick_len(8));
        if (hdr[2:1] != 2'd0) repeat (2) body.push_back(8'($urandom));
        repeat (pick_len(10)) body.push_back(8'($urandom));
        if (broken) begin
            if ($urandom_range(1)) begin
                body[0] = 8'($urandom);
                body[1] = 8'($urandom);
            end else begin
                // declared length too short: runs out early, in the variable header or the payload
                delta = -$urandom_range(1, body.size() - 1);
            end
        end
        send_packet(hdr, body, delta, $urandom_range(7) == 0);
    endtask

    task automatic gen_random_packet();
        int         pick;
        logic [3:0] ptype;
        logic [7:0] hdr;
        pick = $urandom_range(99);
        hdr  = {($urandom_range(1) ? TYPE_CONNECT : TYPE_PUBLISH), 4'($urandom)};
        if (pick < 38) begin
            gen_connect(1'b0);
            connect_pkts++;
        end else if (pick < 76) begin
            gen_publish(1'b0);
            publish_pkts++;
        end else begin
            malformed_pkts++;
            if (pick < 82) begin
                gen_connect(1'b1);
            end else if (pick < 88) begin
                gen_publish(1'b1);
            end else if (pick < 91) begin
                // unsupported type followed by stray bytes
                do ptype = 4'($urandom); while (ptype == TYPE_CONNECT || ptype == TYPE_PUBLISH);
                push_byte({ptype, 4'($urandom)}, 1'b1);
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
            end else if (pick < 94) begin
                // length encoding with a fifth byte
                push_byte(hdr, 1'b1);
                repeat (4) push_byte({1'b1, 7'($urandom)}, 1'b0);
                push_byte(8'($urandom), 1'b0);
            end else if (pick < 96) begin
                push_byte(hdr, 1'b1);
                push_length(0, $urandom_range(1));
            end else if (pick < 99) begin
                // cut short, then the next header arrives mid-packet
                if ($urandom_range(1)) gen_connect(1'b0);
                else gen_publish(1'b0);
                repeat ($urandom_range(1, 3)) void'(pending_bytes.pop_back());
            end else begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'($urandom));
            end
        end
    endtask

    // Returns once every queued byte is transferred and every tag checked
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || item_valid || expected_tags.size() != 0) begin
            @(posedge clk);
            #1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // Stray byte while idle, then an unsupported type
        push_byte(8'h00, 1'b0);
        push_byte(8'hF0, 1'b1);
        // Zero remaining length
        push_byte(8'h30, 1'b1);
        push_byte(8'h00, 1'b0);
        // PUBLISH qos 3 with the largest remaining length, one-byte topic
        push_byte(8'h3F, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // New CONNECT header mid-packet, with a fifth length byte
        push_byte(8'h10, 1'b1);
        repeat (4) push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        // PUBLISH whose topic length overruns the remaining length
        push_byte(8'h32, 1'b1);
        push_byte(8'h02, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(8'hFF, 1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_idle_pct[p];
            recv_stall_pct = phase_stall_pct[p];
            while (pending_bytes.size() < RANDOM_BYTES / 4) gen_random_packet();
            wait_drained();
        end

        // Let any stray late result show up
        repeat (20) @(posedge clk);

        $display("Checked %0d tagged bytes over %0d CONNECT, %0d PUBLISH and %0d malformed packets",
                 bytes_checked, connect_pkts, publish_pkts, malformed_pkts);
        $display("Packet endings: %0d ok, %0d length too long, %0d mismatch, %0d unsupported",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches found", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
